// File: rtl/core/spa_pkg.sv
// Shared types and codes for the sparse polynomial adder.
package spa_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND_FIRST  = 2'd0,
    CMD_APPEND_SECOND = 2'd1,
    CMD_ADD           = 2'd2,
    CMD_CLEAR         = 2'd3
  } cmd_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int CoeffW = 32;
  localparam int PowerW = 16;
  localparam int SumW   = CoeffW + 1;

  // Command queue between front and back; depth is a power of two.
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_MERGE
  } back_state_e;

  typedef struct packed {
    cmd_e                     op;
    logic signed [CoeffW-1:0] coeff;
    logic [PowerW-1:0]        power;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

// File: rtl/core/spa_front.sv
// Front end: takes commands, decodes them and queues them for the back end.
module spa_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [1:0]                          command,
  input  logic signed [spa_pkg::CoeffW-1:0]   term_coeff,
  input  logic [spa_pkg::PowerW-1:0]          term_power,
  input  logic                                pop,
  output logic                                busy,
  output spa_pkg::head_t                      head
);

  localparam int PtrW = $clog2(spa_pkg::QueueDepth);

  spa_pkg::item_t queue [spa_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   fill;
  logic            push;

  assign push = start && !busy;
  assign busy = (fill == (PtrW+1)'(spa_pkg::QueueDepth));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{op: spa_pkg::cmd_e'(command), coeff: term_coeff, power: term_power};
    end
  end

  assign head.valid = (fill != '0);
  assign head.item  = queue[rd_ptr];

endmodule

// File: rtl/core/spa_back.sv
// Back end: term list storage, append/clear handling and the merge sequencer.
module spa_back #(
  parameter int MAX_TERMS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  spa_pkg::head_t                      head,
  output logic                                pop,
  output logic                                strobe,
  output logic signed [spa_pkg::SumW-1:0]     sum_coeff,
  output logic [spa_pkg::PowerW-1:0]          sum_power,
  output logic                                last_term,
  output logic [1:0]                          status
);

  localparam int CntW = $clog2(MAX_TERMS + 1);
  localparam int IdxW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int EntW = spa_pkg::CoeffW + spa_pkg::PowerW;

  logic [EntW-1:0] mem_a [MAX_TERMS];
  logic [EntW-1:0] mem_b [MAX_TERMS];
  logic [EntW-1:0] rd_a;
  logic [EntW-1:0] rd_b;

  spa_pkg::back_state_e state, state_next;
  logic [CntW-1:0] cnt_a, cnt_a_next;
  logic [CntW-1:0] cnt_b, cnt_b_next;
  logic [CntW-1:0] i, i_next;
  logic [CntW-1:0] j, j_next;

  logic                               we_a;
  logic                               we_b;
  logic                               out_next;
  logic signed [spa_pkg::SumW-1:0]    coeff_next;
  logic [spa_pkg::PowerW-1:0]         power_next;
  logic                               last_next;
  logic [1:0]                         status_next;

  logic signed [spa_pkg::CoeffW-1:0]  ca;
  logic signed [spa_pkg::CoeffW-1:0]  cb;
  logic [spa_pkg::PowerW-1:0]         pa;
  logic [spa_pkg::PowerW-1:0]         pb;
  logic                               have_a;
  logic                               have_b;
  logic                               take_a;
  logic                               take_b;

  assign ca = rd_a[EntW-1 -: spa_pkg::CoeffW];
  assign pa = rd_a[spa_pkg::PowerW-1:0];
  assign cb = rd_b[EntW-1 -: spa_pkg::CoeffW];
  assign pb = rd_b[spa_pkg::PowerW-1:0];
  assign have_a = (i < cnt_a);
  assign have_b = (j < cnt_b);

  // Term stores: written on append, read at the merge heads.
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[cnt_a[IdxW-1:0]] <= {head.item.coeff, head.item.power};
    end
    if (we_b) begin
      mem_b[cnt_b[IdxW-1:0]] <= {head.item.coeff, head.item.power};
    end
    rd_a <= mem_a[i[IdxW-1:0]];
    rd_b <= mem_b[j[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= spa_pkg::BK_IDLE;
      cnt_a  <= '0;
      cnt_b  <= '0;
      i      <= '0;
      j      <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      cnt_a  <= cnt_a_next;
      cnt_b  <= cnt_b_next;
      i      <= i_next;
      j      <= j_next;
      strobe <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_next) begin
      sum_coeff <= coeff_next;
      sum_power <= power_next;
      last_term <= last_next;
      status    <= status_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_a_next  = cnt_a;
    cnt_b_next  = cnt_b;
    i_next      = i;
    j_next      = j;
    pop         = 1'b0;
    we_a        = 1'b0;
    we_b        = 1'b0;
    out_next    = 1'b0;
    coeff_next  = '0;
    power_next  = '0;
    last_next   = 1'b1;
    status_next = spa_pkg::ST_OK;
    take_a      = 1'b0;
    take_b      = 1'b0;

    case (state)
      spa_pkg::BK_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.item.op)
            spa_pkg::CMD_APPEND_FIRST: begin
              out_next = 1'b1;
              if (cnt_a == CntW'(MAX_TERMS)) begin
                status_next = spa_pkg::ST_FULL;
              end else begin
                we_a       = 1'b1;
                cnt_a_next = cnt_a + 1'b1;
              end
            end
            spa_pkg::CMD_APPEND_SECOND: begin
              out_next = 1'b1;
              if (cnt_b == CntW'(MAX_TERMS)) begin
                status_next = spa_pkg::ST_FULL;
              end else begin
                we_b       = 1'b1;
                cnt_b_next = cnt_b + 1'b1;
              end
            end
            spa_pkg::CMD_CLEAR: begin
              out_next   = 1'b1;
              cnt_a_next = '0;
              cnt_b_next = '0;
            end
            spa_pkg::CMD_ADD: begin
              i_next = '0;
              j_next = '0;
              if (cnt_a == '0 && cnt_b == '0) begin
                out_next    = 1'b1;
                status_next = spa_pkg::ST_EMPTY;
              end else begin
                state_next = spa_pkg::BK_READ;
              end
            end
            default: begin
              out_next = 1'b1;
            end
          endcase
        end
      end

      // store read of the two heads lands in rd_a / rd_b
      spa_pkg::BK_READ: begin
        state_next = spa_pkg::BK_MERGE;
      end

      spa_pkg::BK_MERGE: begin
        if (have_a && have_b) begin
          take_a = (pa >= pb);
          take_b = (pb >= pa);
        end else begin
          take_a = have_a;
          take_b = !have_a;
        end
        out_next = 1'b1;
        if (take_a && take_b) begin
          coeff_next = {ca[spa_pkg::CoeffW-1], ca} + {cb[spa_pkg::CoeffW-1], cb};
        end else if (take_a) begin
          coeff_next = {ca[spa_pkg::CoeffW-1], ca};
        end else begin
          coeff_next = {cb[spa_pkg::CoeffW-1], cb};
        end
        power_next = take_a ? pa : pb;
        i_next     = i + CntW'(take_a);
        j_next     = j + CntW'(take_b);
        last_next  = (i_next >= cnt_a) && (j_next >= cnt_b);
        state_next = last_next ? spa_pkg::BK_IDLE : spa_pkg::BK_READ;
      end

      default: begin
        state_next = spa_pkg::BK_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt_a <= CntW'(MAX_TERMS)) && (cnt_b <= CntW'(MAX_TERMS)))
    else $error("term count beyond list capacity");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == spa_pkg::BK_IDLE) && head.valid)
    else $error("command taken while merge in progress");

  a_merge_has_term: assert property (@(posedge clk) disable iff (rst)
    (state == spa_pkg::BK_MERGE) |-> ((i < cnt_a) || (j < cnt_b)))
    else $error("merge step with both lists exhausted");

  a_read_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == spa_pkg::BK_READ) |=> !strobe)
    else $error("result emitted on a head read cycle");

  a_merge_result: assert property (@(posedge clk) disable iff (rst)
    (state == spa_pkg::BK_MERGE) |=> strobe)
    else $error("merge step gave no result");

endmodule

// File: rtl/core/sparse_polynomial_adder.sv
// Sparse polynomial adder: two term lists with append, clear and a sorted merge.
//
// Commands go in on start/busy: a command transfers at a rising edge with start
// high and busy low. command selects append to first list, append to second,
// add, or clear; term_coeff/term_power carry the term for appends.
// Results come out on strobe for exactly one cycle each (sum_coeff, sum_power,
// last_term, status); the receiver cannot stall, so every strobe is a transfer.
// Commands sit in a two-entry queue; busy is high while it is full.
// An append or clear result is registered onto the ports once the back end,
// idle, takes its command from the queue head. Append and clear retire one per
// cycle while no add is merging; each gives one result.
// An add steps through a head read from the term store, then a compare and
// emit, for each term it gives, up to 2*MAX_TERMS terms, with last_term on
// the final one; with both lists empty it gives one result with status empty,
// as fast as an append.
// A full list refuses an append and reports status full.
// Reset empties both lists and the queue; the term stores themselves are not
// cleared, only their counts.
module sparse_polynomial_adder #(
  parameter int MAX_TERMS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [1:0]                          command,
  input  logic signed [spa_pkg::CoeffW-1:0]   term_coeff,
  input  logic [spa_pkg::PowerW-1:0]          term_power,
  output logic                                busy,
  output logic                                strobe,
  output logic signed [spa_pkg::SumW-1:0]     sum_coeff,
  output logic [spa_pkg::PowerW-1:0]          sum_power,
  output logic                                last_term,
  output logic [1:0]                          status
);

  spa_pkg::head_t head;
  logic           pop;

  spa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .command    (command),
    .term_coeff (term_coeff),
    .term_power (term_power),
    .pop        (pop),
    .busy       (busy),
    .head       (head)
  );

  spa_back #(
    .MAX_TERMS (MAX_TERMS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .strobe    (strobe),
    .sum_coeff (sum_coeff),
    .sum_power (sum_power),
    .last_term (last_term),
    .status    (status)
  );

endmodule

// File: dv/sparse_polynomial_adder_tb.sv
// Self-checking testbench for the sparse polynomial adder: directed table, then random term lists.
`timescale 1ns / 1ps

module sparse_polynomial_adder_tb;

  localparam int TERM_SLOTS  = 32;
  localparam int N_DIRECTED  = 25;
  localparam int RANDOM_CMDS = 130;
  localparam int QUIET_LIMIT = 2000;
  localparam int REPORT_CAP  = 40;

  typedef struct packed {
    logic signed [spa_pkg::SumW-1:0] coeff;
    logic [spa_pkg::PowerW-1:0]      power;
    logic                            last;
    logic [1:0]                      status;
  } sum_term_t;

  typedef struct {
    spa_pkg::cmd_e                     op;
    logic signed [spa_pkg::CoeffW-1:0] coeff;
    logic [spa_pkg::PowerW-1:0]        power;
    bit                                typed;
    sum_term_t                         want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic [1:0] command;
  logic signed [spa_pkg::CoeffW-1:0] term_coeff;
  logic [spa_pkg::PowerW-1:0] term_power;
  logic busy;
  logic strobe;
  logic signed [spa_pkg::SumW-1:0] sum_coeff;
  logic [spa_pkg::PowerW-1:0] sum_power;
  logic last_term;
  logic [1:0] status;

  // Expectation typed into the directed table, travels with the command
  logic      row_typed;
  sum_term_t row_want;
  bit        no_idle;

  // Predictor state: the two term lists
  logic signed [spa_pkg::CoeffW-1:0] lhs_coeff [TERM_SLOTS];
  logic [spa_pkg::PowerW-1:0]        lhs_power [TERM_SLOTS];
  logic signed [spa_pkg::CoeffW-1:0] rhs_coeff [TERM_SLOTS];
  logic [spa_pkg::PowerW-1:0]        rhs_power [TERM_SLOTS];
  int lhs_len;
  int rhs_len;

  sum_term_t fresh_terms[$];
  sum_term_t pending_terms[$];
  stim_row_t directed [N_DIRECTED];

  int errors;
  int n_sent;
  int n_checked;
  int n_merges;
  int n_refused;
  int quiet_cycles;

  always #2 clk = ~clk;

  sparse_polynomial_adder #(
    .MAX_TERMS(TERM_SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .command(command),
    .term_coeff(term_coeff),
    .term_power(term_power),
    .busy(busy),
    .strobe(strobe),
    .sum_coeff(sum_coeff),
    .sum_power(sum_power),
    .last_term(last_term),
    .status(status)
  );

  function automatic sum_term_t ack(input logic [1:0] st);
    sum_term_t t;
    t = '0;
    t.last = 1'b1;
    t.status = st;
    return t;
  endfunction

  function automatic sum_term_t lone_term(input logic signed [spa_pkg::SumW-1:0] c,
                                          input logic [spa_pkg::PowerW-1:0] p);
    sum_term_t t;
    t = ack(spa_pkg::ST_OK);
    t.coeff = c;
    t.power = p;
    return t;
  endfunction

  function automatic stim_row_t row(input spa_pkg::cmd_e op,
                                    input logic signed [spa_pkg::CoeffW-1:0] c,
                                    input logic [spa_pkg::PowerW-1:0] p, input bit typed,
                                    input sum_term_t want);
    stim_row_t r;
    r.op = op;
    r.coeff = c;
    r.power = p;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // Works out the result terms of one command and updates the lists
  function automatic void predict_cmd(input spa_pkg::cmd_e op,
                                      input logic signed [spa_pkg::CoeffW-1:0] c,
                                      input logic [spa_pkg::PowerW-1:0] p);
    int i;
    int j;
    sum_term_t t;
    fresh_terms.delete();
    i = 0;
    j = 0;
    case (op)
      spa_pkg::CMD_APPEND_FIRST: begin
        if (lhs_len >= TERM_SLOTS) begin
          fresh_terms.push_back(ack(spa_pkg::ST_FULL));
          n_refused++;
        end else begin
          lhs_coeff[lhs_len] = c;
          lhs_power[lhs_len] = p;
          lhs_len++;
          fresh_terms.push_back(ack(spa_pkg::ST_OK));
        end
      end
      spa_pkg::CMD_APPEND_SECOND: begin
        if (rhs_len >= TERM_SLOTS) begin
          fresh_terms.push_back(ack(spa_pkg::ST_FULL));
          n_refused++;
        end else begin
          rhs_coeff[rhs_len] = c;
          rhs_power[rhs_len] = p;
          rhs_len++;
          fresh_terms.push_back(ack(spa_pkg::ST_OK));
        end
      end
      spa_pkg::CMD_CLEAR: begin
        lhs_len = 0;
        rhs_len = 0;
        fresh_terms.push_back(ack(spa_pkg::ST_OK));
      end
      default: begin
        if (lhs_len == 0 && rhs_len == 0) begin
          fresh_terms.push_back(ack(spa_pkg::ST_EMPTY));
        end else begin
          n_merges++;
          while (i < lhs_len || j < rhs_len) begin
            t = '0;
            t.status = spa_pkg::ST_OK;
            if (i < lhs_len && j < rhs_len && lhs_power[i] == rhs_power[j]) begin
              // both signed, so the 33-bit sum is sign extended
              t.coeff = lhs_coeff[i] + rhs_coeff[j];
              t.power = lhs_power[i];
              i++;
              j++;
            end else if (j < rhs_len && (i >= lhs_len || rhs_power[j] > lhs_power[i])) begin
              t.coeff = rhs_coeff[j];
              t.power = rhs_power[j];
              j++;
            end else begin
              t.coeff = lhs_coeff[i];
              t.power = lhs_power[i];
              i++;
            end
            t.last = (i >= lhs_len && j >= rhs_len);
            fresh_terms.push_back(t);
          end
        end
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    errors++;
    if (errors <= REPORT_CAP) $display("%0t ns mismatch: %s", $time, what);
  endtask

  // Result checking and command prediction, both on the rising edge
  always @(posedge clk) begin
    sum_term_t want;
    if (!rst) begin
      if (strobe) begin
        if (pending_terms.size() == 0) begin
          flag_mismatch($sformatf("unexpected term coeff %0d power %0d status %0d",
                                  sum_coeff, sum_power, status));
        end else begin
          want = pending_terms.pop_front();
          if (sum_coeff !== want.coeff)
            flag_mismatch($sformatf("term %0d sum_coeff %0d, want %0d",
                                    n_checked, sum_coeff, want.coeff));
          if (sum_power !== want.power)
            flag_mismatch($sformatf("term %0d sum_power %0d, want %0d",
                                    n_checked, sum_power, want.power));
          if (last_term !== want.last)
            flag_mismatch($sformatf("term %0d last_term %0b, want %0b",
                                    n_checked, last_term, want.last));
          if (status !== want.status)
            flag_mismatch($sformatf("term %0d status %0d, want %0d",
                                    n_checked, status, want.status));
        end
        n_checked++;
      end
      if (start && !busy) begin
        predict_cmd(spa_pkg::cmd_e'(command), term_coeff, term_power);
        if (row_typed) pending_terms.push_back(row_want);
        else foreach (fresh_terms[k]) pending_terms.push_back(fresh_terms[k]);
      end
    end
  end

  // Ends a run that stops making progress
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sparse_polynomial_adder_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [spa_pkg::CoeffW-1:0] rand_coeff();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cmd(input spa_pkg::cmd_e op,
                          input logic signed [spa_pkg::CoeffW-1:0] c,
                          input logic [spa_pkg::PowerW-1:0] p, input bit typed,
                          input sum_term_t want);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
      command = 2'($urandom);
      term_coeff = $urandom;
      term_power = 16'($urandom);
      row_typed = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    command = op;
    term_coeff = c;
    term_power = p;
    row_typed = typed;
    row_want = want;
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  // Clear, fill both lists (descending powers, shared ones likely; random if shuffled), then add
  task automatic run_sequence(input int n_lhs, input int n_rhs, input bit shuffled);
    int k_lhs;
    int k_rhs;
    logic [spa_pkg::PowerW-1:0] p_lhs;
    logic [spa_pkg::PowerW-1:0] p_rhs;
    bit to_rhs;
    k_lhs = 0;
    k_rhs = 0;
    p_lhs = 16'($urandom_range(120, 65535));
    if ($urandom_range(0, 5) == 0) p_lhs = 16'hFFFF;
    p_rhs = p_lhs;
    send_cmd(spa_pkg::CMD_CLEAR, $urandom, 16'($urandom), 1'b0, '0);
    while (k_lhs < n_lhs || k_rhs < n_rhs) begin
      to_rhs = (k_lhs >= n_lhs) || (k_rhs < n_rhs && $urandom_range(0, 1) == 1);
      if (to_rhs) begin
        send_cmd(spa_pkg::CMD_APPEND_SECOND, rand_coeff(),
                 shuffled ? 16'($urandom) : p_rhs, 1'b0, '0);
        p_rhs = p_rhs - 16'($urandom_range(1, 3));
        k_rhs++;
      end else begin
        send_cmd(spa_pkg::CMD_APPEND_FIRST, rand_coeff(),
                 shuffled ? 16'($urandom) : p_lhs, 1'b0, '0);
        p_lhs = p_lhs - 16'($urandom_range(1, 3));
        k_lhs++;
      end
    end
    send_cmd(spa_pkg::CMD_ADD, $urandom, 16'($urandom), 1'b0, '0);
    // an add leaves the lists alone, so a repeat gives the same terms
    if ($urandom_range(0, 3) == 0)
      send_cmd(spa_pkg::CMD_ADD, $urandom, 16'($urandom), 1'b0, '0);
  endtask

  function automatic int pick_len();
    if ($urandom_range(0, 7) == 0) return $urandom_range(6, TERM_SLOTS);
    return $urandom_range(0, 5);
  endfunction

  initial begin
    int random_base;
    rst = 1'b1;
    start = 1'b0;
    command = spa_pkg::CMD_CLEAR;
    term_coeff = '0;
    term_power = '0;
    row_typed = 1'b0;
    row_want = '0;
    no_idle = 1'b0;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_merges = 0;
    n_refused = 0;
    lhs_len = 0;
    rhs_len = 0;

    directed = '{
      row(spa_pkg::CMD_ADD,           0,              0,        1,
          ack(spa_pkg::ST_EMPTY)),
      row(spa_pkg::CMD_CLEAR,         0,              0,        1, ack(spa_pkg::ST_OK)),
      row(spa_pkg::CMD_APPEND_FIRST,  32'sh8000_0000, 16'hFFFF, 1, ack(spa_pkg::ST_OK)),
      row(spa_pkg::CMD_APPEND_SECOND, 32'sh8000_0000, 16'hFFFF, 1, ack(spa_pkg::ST_OK)),
      // most negative coefficients at equal power: sum needs the 33rd bit
      row(spa_pkg::CMD_ADD,           0,              0,        1,
          lone_term(33'h1_0000_0000, 16'hFFFF)),
      row(spa_pkg::CMD_CLEAR,         0,              0,        1, ack(spa_pkg::ST_OK)),
      row(spa_pkg::CMD_APPEND_FIRST,  32'sh7FFF_FFFF, 16'hFFFF, 1, ack(spa_pkg::ST_OK)),
      row(spa_pkg::CMD_APPEND_SECOND, 32'sh7FFF_FFFF, 16'hFFFF, 1, ack(spa_pkg::ST_OK)),
      row(spa_pkg::CMD_ADD,           0,              0,        1,
          lone_term(33'h0_FFFF_FFFE, 16'hFFFF)),
      row(spa_pkg::CMD_APPEND_FIRST,  1000,           300,      1, ack(spa_pkg::ST_OK)),
      // cancels at power 300: zero term still goes out
      row(spa_pkg::CMD_APPEND_SECOND, -1000,          300,      1, ack(spa_pkg::ST_OK)),
      row(spa_pkg::CMD_APPEND_FIRST,  42,             0,        1, ack(spa_pkg::ST_OK)),
      row(spa_pkg::CMD_APPEND_SECOND, 7,              12,       1, ack(spa_pkg::ST_OK)),
      row(spa_pkg::CMD_ADD,           0,              0,        0, '0),
      row(spa_pkg::CMD_CLEAR,         0,              0,        1, ack(spa_pkg::ST_OK)),
      // first list out of order, two terms left after second runs out
      row(spa_pkg::CMD_APPEND_FIRST,  3,              10,       1, ack(spa_pkg::ST_OK)),
      row(spa_pkg::CMD_APPEND_FIRST,  4,              20,       1, ack(spa_pkg::ST_OK)),
      row(spa_pkg::CMD_APPEND_SECOND, 5,              15,       1, ack(spa_pkg::ST_OK)),
      row(spa_pkg::CMD_ADD,           0,              0,        0, '0),
      row(spa_pkg::CMD_CLEAR,         0,              0,        1, ack(spa_pkg::ST_OK)),
      row(spa_pkg::CMD_APPEND_SECOND, -1,             100,      1, ack(spa_pkg::ST_OK)),
      row(spa_pkg::CMD_APPEND_SECOND, 2,              50,       1, ack(spa_pkg::ST_OK)),
      row(spa_pkg::CMD_ADD,           0,              0,        0, '0),
      row(spa_pkg::CMD_ADD,           0,              0,        0, '0),
      row(spa_pkg::CMD_CLEAR,         0,              0,        1, ack(spa_pkg::ST_OK))
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[k])
      send_cmd(directed[k].op, directed[k].coeff, directed[k].power,
               directed[k].typed, directed[k].want);

    // Both lists full plus refused appends: the longest add
    random_base = n_sent;
    run_sequence(TERM_SLOTS + 2, TERM_SLOTS + 1, 1'b0);
    while (n_sent - random_base < RANDOM_CMDS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(3, 10))
            send_cmd(spa_pkg::cmd_e'($urandom_range(0, 3)), $urandom, 16'($urandom),
                     1'b0, '0);
        end
        1: run_sequence(pick_len(), pick_len(), 1'b1);
        default: run_sequence(pick_len(), pick_len(), 1'b0);
      endcase
    end
    no_idle = 1'b0;

    @(negedge clk);
    start = 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d commands (%0d merges, %0d refused appends)",
             n_sent, n_merges, n_refused);
    $display("Checked %0d result terms, %0d mismatches", n_checked, errors);
    if (errors == 0 && pending_terms.size() == 0) begin
      $display("sparse_polynomial_adder_tb: clean");
    end else begin
      $display("sparse_polynomial_adder_tb: errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/spa_pkg.sv
rtl/core/spa_front.sv
rtl/core/spa_back.sv
rtl/core/sparse_polynomial_adder.sv
dv/sparse_polynomial_adder_tb.sv
